FILE: rtl/nqt_pkg.sv
// ----------------------------------------------------------------------------
// nqt_pkg
// Shared types, constants and helpers of the nested quote tokenizer.
// ----------------------------------------------------------------------------
package nqt_pkg;

   localparam int MAX_PAIRS_DEF   = 4;
   localparam int STACK_DEPTH_DEF = 16;

   localparam int CHAR_W      = 8;
   localparam int PAIR_CNT_W  = 3;
   localparam int CHARS_W     = 32;
   localparam int REG_PAIRS   = CHARS_W / CHAR_W;
   localparam int DEPTH_OUT_W = 5;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CHAR_W-1:0] DELIM_RESET = 8'd44;

   typedef enum logic [1:0] {
      REG_DELIMITER  = 2'd0,
      REG_PAIR_COUNT = 2'd1,
      REG_OPEN       = 2'd2,
      REG_CLOSE      = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [CHAR_W-1:0]     delimiter_char;
      logic [PAIR_CNT_W-1:0] pair_count;
      logic [CHARS_W-1:0]    open_chars;
      logic [CHARS_W-1:0]    close_chars;
   } cfg_type;

   // shift command for the stack cells
   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctl_type;

   // pair matcher verdict
   typedef struct packed {
      logic hit;
      logic pop;
   } match_type;

   // byte of pair i in a packed char register; pairs past the register read 0
   function automatic logic [CHAR_W-1:0] pair_byte(logic [CHARS_W-1:0] r, int i);
      if (i >= REG_PAIRS) begin
         return '0;
      end
      return r[CHAR_W*i +: CHAR_W];
   endfunction

endpackage

FILE: rtl/nested_quote_tokenizer_core.sv
// ----------------------------------------------------------------------------
// nested_quote_tokenizer_core
// Splits a byte stream into tokens at a delimiter, ignoring delimiters inside
// nested quote or bracket pairs tracked on a shift stack of cells.
//
//   port group   dir  payload
//   req_*        in   tdata[7:0] in_char, tlast last_char
//   rsp_*        out  tdata: out_char, flags, nest_depth, overflow; tlast
//   csr_*        in   APB-style register port, regs at 0x0/0x4/0x8/0xC
//
// One byte per cycle while the output is taken: the pair compare and one
// stack shift settle in the accept cycle, and the stack row shifts at that
// edge; the result is registered in the output register at the same edge.
// req_tready stays high while the output register is empty or being taken.
// Synchronous reset clears pointer, token flag and output valid; no clear
// pass, stack slots above the pointer are never read.
// ----------------------------------------------------------------------------
module nested_quote_tokenizer_core #(
   parameter int MAX_PAIRS   = nqt_pkg::MAX_PAIRS_DEF,
   parameter int STACK_DEPTH = nqt_pkg::STACK_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [nqt_pkg::CHAR_W-1:0]     req_tdata,  // [7:0] in_char
   input  logic                           req_tlast,  // last_char
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] out_char, [8] in_token, [9] token_first, [10] token_end,
   // [15:11] nest_depth, [16] overflow, [23:17] zero
   output logic [nqt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,  // last_out
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [nqt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [nqt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [nqt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import nqt_pkg::*;

   localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

   cfg_type     cfg;
   match_type   match;
   stk_ctl_type stk_ctl;
   logic [IDX_W-1:0] push_idx;
   logic [IDX_W-1:0] cell_idx [STACK_DEPTH];

   logic [SP_W-1:0] sp_ff, sp_in;
   logic            tok_ff, tok_in;
   logic            vld_ff, vld_in;

   logic [CHAR_W-1:0]      char_ff;
   logic                   member_ff, first_ff, end_ff, ovf_ff, last_ff;
   logic [DEPTH_OUT_W-1:0] depth_ff;

   logic            accept, enclosed, is_delim, member, first, tok_end, ovf;
   logic [SP_W-1:0] sp_step;
   logic [CHAR_W-1:0] in_char;

   assign in_char = req_tdata;

   nqt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   nqt_pair_match #(
      .MAX_PAIRS (MAX_PAIRS),
      .IDX_W     (IDX_W)
   ) u_match (
      .cfg      (cfg),
      .in_char  (in_char),
      .enclosed (enclosed),
      .top_idx  (cell_idx[0]),
      .match    (match),
      .push_idx (push_idx)
   );

   // cell 0 is top of stack
   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
      nqt_stack_cell #(
         .IDX_W (IDX_W)
      ) u_cell (
         .clock    (clock),
         .ctl      (stk_ctl),
         .prev_idx ((g == 0) ? push_idx : cell_idx[(g == 0) ? 0 : g - 1]),
         .next_idx (cell_idx[(g == STACK_DEPTH - 1) ? g : g + 1]),
         .idx_q    (cell_idx[g])
      );
   end

   assign req_tready = !vld_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      enclosed     = (sp_ff != '0);
      is_delim     = (in_char == cfg.delimiter_char);
      member       = !is_delim || enclosed;
      first        = member && !tok_ff;
      stk_ctl.pop  = accept && member && match.hit && match.pop;
      stk_ctl.push = accept && member && match.hit && !match.pop && (sp_ff != SP_FULL);
      ovf          = member && match.hit && !match.pop && (sp_ff == SP_FULL);

      sp_step = sp_ff;
      if (stk_ctl.push) begin
         sp_step = sp_ff + SP_W'(1);
      end else if (stk_ctl.pop) begin
         sp_step = sp_ff - SP_W'(1);
      end

      tok_in  = tok_ff;
      sp_in   = sp_ff;
      tok_end = (!member && tok_ff) || (req_tlast && member);
      if (accept) begin
         tok_in = member;
         sp_in  = sp_step;
         if (req_tlast) begin
            tok_in = 1'b0;
            sp_in  = '0;
         end
      end

      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= '0;
         tok_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         sp_ff  <= sp_in;
         tok_ff <= tok_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff   <= in_char;
         member_ff <= member;
         first_ff  <= first;
         end_ff    <= tok_end;
         depth_ff  <= DEPTH_OUT_W'(sp_step);
         ovf_ff    <= ovf;
         last_ff   <= req_tlast;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'b0, ovf_ff, depth_ff, end_ff, first_ff, member_ff, char_ff};

`ifndef SYNTH
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_FULL)
      else $error("stack pointer past depth");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> (sp_ff == '0) && !tok_ff)
      else $error("state not cleared after last byte");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      accept && ovf |-> sp_ff == SP_FULL)
      else $error("overflow with room on stack");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      stk_ctl.pop |-> sp_ff != '0)
      else $error("pop of empty stack");

   a_first_member: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && first_ff |-> member_ff)
      else $error("token start on non-member byte");
`endif

endmodule

FILE: rtl/nqt_stack_cell.sv
// ----------------------------------------------------------------------------
// nqt_stack_cell
// One slot of the shift stack: takes its upper neighbor's entry on a push
// and its lower neighbor's entry on a pop.
// ----------------------------------------------------------------------------
module nqt_stack_cell #(
   parameter int IDX_W = 2
) (
   input  logic                 clock,
   input  nqt_pkg::stk_ctl_type ctl,
   input  logic [IDX_W-1:0]     prev_idx,
   input  logic [IDX_W-1:0]     next_idx,
   output logic [IDX_W-1:0]     idx_q
);
   import nqt_pkg::*;

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;

   always_comb begin
      idx_in = idx_ff;
      if (ctl.push) begin
         idx_in = prev_idx;
      end else if (ctl.pop) begin
         idx_in = next_idx;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   assign idx_q = idx_ff;

endmodule

FILE: rtl/nqt_pair_match.sv
// ----------------------------------------------------------------------------
// nqt_pair_match
// Parallel compare of one byte against the first pair_count pairs, first pair wins.
// ----------------------------------------------------------------------------
module nqt_pair_match #(
   parameter int MAX_PAIRS = nqt_pkg::MAX_PAIRS_DEF,
   parameter int IDX_W     = 2
) (
   input  nqt_pkg::cfg_type          cfg,
   input  logic [nqt_pkg::CHAR_W-1:0] in_char,
   input  logic                      enclosed,
   input  logic [IDX_W-1:0]          top_idx,
   output nqt_pkg::match_type        match,
   output logic [IDX_W-1:0]          push_idx
);
   import nqt_pkg::*;

   logic [CHAR_W-1:0] top_open;

   // open byte of the pair on top of the stack
   always_comb begin
      top_open = '0;
      if (int'(top_idx) < REG_PAIRS) begin
         top_open = CHAR_W'(cfg.open_chars >> {top_idx, 3'b000});
      end
   end

   always_comb begin
      logic              found;
      logic [CHAR_W-1:0] op;
      logic              pop_hit;
      found    = 1'b0;
      match    = '0;
      push_idx = '0;
      for (int i = 0; i < MAX_PAIRS; i++) begin
         op      = pair_byte(cfg.open_chars, i);
         pop_hit = enclosed && (in_char == pair_byte(cfg.close_chars, i))
                   && (op == top_open);
         if (!found && (int'(cfg.pair_count) > i)) begin
            if (pop_hit) begin
               found     = 1'b1;
               match.hit = 1'b1;
               match.pop = 1'b1;
            end else if (in_char == op) begin
               found     = 1'b1;
               match.hit = 1'b1;
               push_idx  = IDX_W'(i);
            end
         end
      end
   end

endmodule

FILE: rtl/nqt_csr.sv
// ----------------------------------------------------------------------------
// nqt_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module nqt_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [nqt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [nqt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [nqt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output nqt_pkg::cfg_type              cfg
);
   import nqt_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type sel;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign sel        = reg_idx_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            REG_DELIMITER:  cfg_in.delimiter_char = csr_pwdata[CHAR_W-1:0];
            REG_PAIR_COUNT: cfg_in.pair_count     = csr_pwdata[PAIR_CNT_W-1:0];
            REG_OPEN:       cfg_in.open_chars     = csr_pwdata;
            REG_CLOSE:      cfg_in.close_chars    = csr_pwdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_DELIMITER:  csr_prdata = CSR_DATA_W'(cfg_ff.delimiter_char);
         REG_PAIR_COUNT: csr_prdata = CSR_DATA_W'(cfg_ff.pair_count);
         REG_OPEN:       csr_prdata = cfg_ff.open_chars;
         REG_CLOSE:      csr_prdata = cfg_ff.close_chars;
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter_char <= DELIM_RESET;
         cfg_ff.pair_count     <= '0;
         cfg_ff.open_chars     <= '0;
         cfg_ff.close_chars    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
